// ===== hdl/rgbps_pkg.sv =====
// Shared constants, command codes and store request type for the LED serial driver.
`timescale 1ns / 1ps

package rgbps_pkg;

    // Geometry of the colour store and the frame
    localparam int LED_COUNT     = 8;
    localparam int LATCH_SLOTS   = 48;
    localparam int WORD_W        = 24;
    localparam int BITS_PER_WORD = 24;

    localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int LED_POS_W = $clog2(LED_COUNT + 1);
    localparam int BIT_POS_W = $clog2(BITS_PER_WORD);
    localparam int LATCH_W   = (LATCH_SLOTS > 1) ? $clog2(LATCH_SLOTS) : 1;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int PIX_W    = 10;
    localparam int CHAN_W   = 8;
    localparam int PERIOD_W = 17;
    localparam int CNT_W    = 17;
    localparam int THR_W    = 24;

    // Bit period limits and duty ratios (percent)
    localparam int PERIOD_MIN   = 2;
    localparam int PERIOD_MAX   = 65536;
    localparam int PERIOD_RESET = 100;
    localparam int DUTY_ZERO    = 34;
    localparam int DUTY_ONE     = 66;
    localparam int DUTY_SCALE   = 100;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_FILL  = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_SHOW  = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    // One cycle's worth of colour store traffic
    typedef struct packed {
        logic                 wr_en;
        logic [LED_IDX_W-1:0] wr_addr;
        logic [WORD_W-1:0]    wr_data;
        logic                 set_all;
        logic                 clear;
        logic                 rd_en;
        logic [LED_IDX_W-1:0] rd_addr;
    } store_req_t;

endpackage

// ===== hdl/rgbps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rgbps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rgbps_store.sv =====
// Colour store: RAM plus per-entry valid bits so that reset and clear act at once.
`timescale 1ns / 1ps

module rgbps_store
    import rgbps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_req_t        req,
    output logic [WORD_W-1:0] rd_data
);

    logic [LED_COUNT-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [WORD_W-1:0]    ram_q;

    rgbps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LED_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (ram_q)
    );

    // Valid bits: clear drops all, fill raises all, a write raises its own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.set_all)
        begin
            valid_reg <= '1;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Valid bit is registered alongside the read data, under the same read enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // An entry never written since reset or clear reads as zero
    assign rd_data = ram_q & {WORD_W{rd_valid_reg}};

endmodule

// ===== hdl/rgb_led_pulse_width_serializer_core.sv =====
// Top level of the LED serial driver: command decode, bit timing and result register.
`timescale 1ns / 1ps

//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------
//  command   | start in, busy out         | cmd, pixel_index, red, green, blue
//  result    | result_valid out (1 cycle) | line_level, busy_res, frame_done
//  config    | cfg_valid in, cfg_ready out| cfg_data (period_counts)
//
//  Every item gives its result in the cycle after acceptance. A plain tick leaves
//  the core idle, so ticks can be issued every cycle; a tick into the next LED word
//  of a frame and a show command hold busy in ST_LOAD for the colour store RAM read.
//  Write and clear leave the core idle; fill writes entry 0, the rest in ST_FILL,
//  one RAM write each. Reset is asynchronous; the store reads zero at once through
//  its valid bits, no clearing pass. The receiver cannot stall results.

module rgb_led_pulse_width_serializer_core
    import rgbps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [PIX_W-1:0]    pixel_index,
    input  logic [CHAN_W-1:0]   red,
    input  logic [CHAN_W-1:0]   green,
    input  logic [CHAN_W-1:0]   blue,
    output logic                result_valid,
    output logic                line_level,
    output logic                busy_res,
    output logic                frame_done,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_FILL = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic                   sending_reg, sending_next;
    logic [LED_POS_W-1:0]   led_pos_reg, led_pos_next;
    logic [BIT_POS_W-1:0]   bit_pos_reg, bit_pos_next;
    logic [LATCH_W-1:0]     latch_reg, latch_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [WORD_W-1:0]      shifter_reg, shifter_next;
    logic [LED_IDX_W-1:0]   fill_pos_reg, fill_pos_next;
    logic [WORD_W-1:0]      fill_word_reg, fill_word_next;
    logic [PERIOD_W-1:0]    period_reg;
    logic [THR_W-1:0]       thr_zero_reg, thr_one_reg;
    logic                   res_valid_reg, res_valid_next;
    logic                   line_reg, line_next;
    logic                   busy_res_reg, busy_res_next;
    logic                   done_reg, done_next;

    logic                   accept;
    logic                   cfg_write;
    logic [PERIOD_W-1:0]    period_eff;
    logic [WORD_W-1:0]      in_word;
    logic [CNT_W:0]         cnt_inc;
    logic [THR_W-1:0]       cnt_scaled;
    logic                   period_end;
    logic [LED_POS_W-1:0]   led_inc;
    logic [WORD_W-1:0]      store_q;
    store_req_t             store_req;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_word   = {green, red, blue};

    // Clamp the written period into its legal range
    always_comb
    begin
        if (cfg_data < PERIOD_W'(PERIOD_MIN))
        begin
            period_eff = PERIOD_W'(PERIOD_MIN);
        end
        else if (cfg_data > PERIOD_W'(PERIOD_MAX))
        begin
            period_eff = PERIOD_W'(PERIOD_MAX);
        end
        else
        begin
            period_eff = cfg_data;
        end
    end

    // Period and scaled duty thresholds, kept as P*duty to avoid a divide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_W'(PERIOD_RESET);
            thr_zero_reg <= THR_W'(PERIOD_RESET * DUTY_ZERO);
            thr_one_reg  <= THR_W'(PERIOD_RESET * DUTY_ONE);
        end
        else if (cfg_write)
        begin
            period_reg   <= period_eff;
            thr_zero_reg <= THR_W'(period_eff) * THR_W'(DUTY_ZERO);
            thr_one_reg  <= THR_W'(period_eff) * THR_W'(DUTY_ONE);
        end
    end

    // Count arithmetic: high while count < floor(P*d/100), i.e. 100*(count+1) <= P*d
    assign cnt_inc    = {1'b0, count_reg} + 1'b1;
    assign cnt_scaled = THR_W'(cnt_inc) * THR_W'(DUTY_SCALE);
    assign period_end = (cnt_inc >= {1'b0, period_reg});
    assign led_inc    = led_pos_reg + 1'b1;

    rgbps_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_q)
    );

    // Command decode, bit timing and store sequencing
    always_comb
    begin
        state_next     = state_reg;
        sending_next   = sending_reg;
        led_pos_next   = led_pos_reg;
        bit_pos_next   = bit_pos_reg;
        latch_next     = latch_reg;
        count_next     = count_reg;
        shifter_next   = shifter_reg;
        fill_pos_next  = fill_pos_reg;
        fill_word_next = fill_word_reg;
        res_valid_next = 1'b0;
        line_next      = line_reg;
        busy_res_next  = busy_res_reg;
        done_next      = done_reg;
        store_req      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b1;
                    line_next      = 1'b0;
                    done_next      = 1'b0;
                    if (cmd == CMD_TICK)
                    begin
                        busy_res_next = sending_reg;
                        if (sending_reg)
                        begin
                            if (led_pos_reg < LED_POS_W'(LED_COUNT))
                            begin
                                // data bit
                                line_next = (cnt_scaled <= (shifter_reg[WORD_W-1] ?
                                             thr_one_reg : thr_zero_reg));
                                if (period_end)
                                begin
                                    count_next   = '0;
                                    shifter_next = {shifter_reg[WORD_W-2:0], 1'b0};
                                    if (bit_pos_reg == BIT_POS_W'(BITS_PER_WORD - 1))
                                    begin
                                        bit_pos_next = '0;
                                        led_pos_next = led_inc;
                                        if (led_inc < LED_POS_W'(LED_COUNT))
                                        begin
                                            store_req.rd_en   = 1'b1;
                                            store_req.rd_addr = led_inc[LED_IDX_W-1:0];
                                            state_next        = ST_LOAD;
                                        end
                                    end
                                    else
                                    begin
                                        bit_pos_next = bit_pos_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    count_next = cnt_inc[CNT_W-1:0];
                                end
                            end
                            else
                            begin
                                // reset slots, line low
                                if (period_end)
                                begin
                                    count_next = '0;
                                    if (latch_reg == LATCH_W'(LATCH_SLOTS - 1))
                                    begin
                                        sending_next = 1'b0;
                                        done_next    = 1'b1;
                                        latch_next   = '0;
                                        led_pos_next = '0;
                                        bit_pos_next = '0;
                                        shifter_next = '0;
                                    end
                                    else
                                    begin
                                        latch_next = latch_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    count_next = cnt_inc[CNT_W-1:0];
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (!sending_reg)
                        begin
                            unique case (cmd)
                                CMD_WRITE:
                                begin
                                    if ({1'b0, pixel_index} < (PIX_W + 1)'(LED_COUNT))
                                    begin
                                        store_req.wr_en   = 1'b1;
                                        store_req.wr_addr = pixel_index[LED_IDX_W-1:0];
                                        store_req.wr_data = in_word;
                                    end
                                end
                                CMD_FILL:
                                begin
                                    store_req.wr_en   = 1'b1;
                                    store_req.wr_addr = '0;
                                    store_req.wr_data = in_word;
                                    store_req.set_all = 1'b1;
                                    fill_word_next    = in_word;
                                    if (LED_COUNT > 1)
                                    begin
                                        fill_pos_next = LED_IDX_W'(1);
                                        state_next    = ST_FILL;
                                    end
                                end
                                CMD_CLEAR:
                                begin
                                    store_req.clear = 1'b1;
                                end
                                CMD_SHOW:
                                begin
                                    sending_next      = 1'b1;
                                    led_pos_next      = '0;
                                    bit_pos_next      = '0;
                                    latch_next        = '0;
                                    count_next        = '0;
                                    store_req.rd_en   = 1'b1;
                                    store_req.rd_addr = '0;
                                    state_next        = ST_LOAD;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        busy_res_next = sending_next;
                    end
                end
            end
            ST_LOAD:
            begin
                // store word arrives in the cycle after the read
                shifter_next = store_q;
                state_next   = ST_IDLE;
            end
            ST_FILL:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = fill_pos_reg;
                store_req.wr_data = fill_word_reg;
                if (fill_pos_reg == LED_IDX_W'(LED_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_pos_next = fill_pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sending_reg   <= 1'b0;
            led_pos_reg   <= '0;
            bit_pos_reg   <= '0;
            latch_reg     <= '0;
            count_reg     <= '0;
            shifter_reg   <= '0;
            fill_pos_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sending_reg   <= sending_next;
            led_pos_reg   <= led_pos_next;
            bit_pos_reg   <= bit_pos_next;
            latch_reg     <= latch_next;
            count_reg     <= count_next;
            shifter_reg   <= shifter_next;
            fill_pos_reg  <= fill_pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_word_reg <= fill_word_next;
        line_reg      <= line_next;
        busy_res_reg  <= busy_res_next;
        done_reg      <= done_next;
    end

    assign result_valid = res_valid_reg;
    assign line_level   = line_reg;
    assign busy_res     = busy_res_reg;
    assign frame_done   = done_reg;

    // Every accepted item answers in the next cycle, and only then
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("result missing after accepted item");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !result_valid)
        else $error("result without accepted item");

    // A show command from idle must fetch the first word
    a_show_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_SHOW) && !sending_reg) |=> (state_reg == ST_LOAD))
        else $error("show did not fetch first word");

    // The frame only ends on a frame_done result, which still reports busy
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sending_reg) |-> (result_valid && frame_done && busy_res))
        else $error("frame ended without frame_done");

endmodule
